// ===== design/lsch_pkg.sv =====
// ----------------------------------------------------------------------------
// lsch_pkg
// shared types and codes of the lottery scheduler
// ----------------------------------------------------------------------------
package lsch_pkg;

  // cell operation, broadcast to every cell of the row
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_REMOVE = 2'd1,
    OP_INSERT = 2'd2,
    OP_ROTATE = 2'd3
  } cell_op_t;

  // control group handed to the cell row
  typedef struct packed {
    cell_op_t op;
  } cell_ctl_t;

  // result status codes
  localparam logic [2:0] ST_WINNER  = 3'd0;
  localparam logic [2:0] ST_IDLE    = 3'd1;
  localparam logic [2:0] ST_RETRY   = 3'd2;
  localparam logic [2:0] ST_INSERTED = 3'd3;
  localparam logic [2:0] ST_BAD_ID  = 3'd4;

  // request types
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_DRAW   = 1'b1;

  // random span and divider width
  localparam int DIV_W = 32;
  localparam logic [31:0] RAND_SPAN = 32'h8000_0000;

  // controller states, one-hot
  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_REMOVE = 8'b0000_0010,
    S_INSERT = 8'b0000_0100,
    S_SUM    = 8'b0000_1000,
    S_EVAL   = 8'b0001_0000,
    S_DIV1   = 8'b0010_0000,
    S_DIV2   = 8'b0100_0000,
    S_WALK   = 8'b1000_0000
  } state_t;

endpackage

// ===== design/lottery_scheduler.sv =====
// ----------------------------------------------------------------------------
// lottery_scheduler
// sorted client row with insert and lottery draw requests
// ----------------------------------------------------------------------------
// channel   direction  handshake           payload
// in_       input      start / busy        in_req_type in_client_id in_tickets
//                                           in_random_word
// out_      output     out_valid strobe    out_status out_winner_id
//
// insert: a bad id is answered straight from idle, otherwise a remove pass
// and then an insert pass; draw: a sum pass rotating the row, then up to
// two divides, then a walk pass rotating the row; an empty row, zero tickets,
// a single client or a rejected random word (retry) end it early
// reset empties the row at once; results are strobed for one cycle
module lottery_scheduler #(
  parameter int TABLE_DEPTH = 64,
  parameter int TICKET_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_req_type,
  input  logic [6:0]  in_client_id,
  input  logic [15:0] in_tickets,
  input  logic [30:0] in_random_word,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [5:0]  out_winner_id
);

  localparam int ID_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int TKT_W = TICKET_BITS;
  localparam int SUM_W = TICKET_BITS + $clog2(TABLE_DEPTH) + 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH) + 1;
  localparam int W     = lsch_pkg::DIV_W;

  lsch_pkg::state_t    state_r, state_nxt;
  lsch_pkg::cell_ctl_t ctl;

  logic [ID_W-1:0]  kid_r;
  logic [TKT_W-1:0] ktkt_r;
  logic [30:0]      word_r;
  logic [CNT_W-1:0] step_r, step_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [ID_W-1:0]  first_r, first_nxt;
  logic [W-1:0]     choice_r, choice_nxt;
  logic             found_r, found_nxt;
  logic [ID_W-1:0]  win_r, win_nxt;
  logic             ov_r, ov_nxt;
  logic [2:0]       ost_r, ost_nxt;
  logic [5:0]       owin_r, owin_nxt;
  logic             dgo_r, dgo_nxt;
  logic [W-1:0]     da_r, da_nxt, db_r, db_nxt;
  logic             ddone;
  logic [W-1:0]     dq, drem;
  logic [W-1:0]     sumc;
  logic [SUM_W-1:0] acc_new;
  logic             last_step;

  logic             c_valid [TABLE_DEPTH];
  logic [ID_W-1:0]  c_id    [TABLE_DEPTH];
  logic [TKT_W-1:0] c_tkt   [TABLE_DEPTH];
  logic             c_flag  [TABLE_DEPTH];

  // cell row
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic             lv, rv, fin;
    logic [ID_W-1:0]  li, ri;
    logic [TKT_W-1:0] lt, rt;
    if (i == 0) begin : g_first
      assign lv  = 1'b0;
      assign li  = kid_r;
      assign lt  = ktkt_r;
      assign fin = 1'b0;
    end else begin : g_mid
      assign lv  = c_valid[i-1];
      assign li  = c_id[i-1];
      assign lt  = c_tkt[i-1];
      assign fin = c_flag[i-1];
    end
    if (i == TABLE_DEPTH - 1) begin : g_last
      assign rv = (ctl.op == lsch_pkg::OP_ROTATE) ? c_valid[0] : 1'b0;
      assign ri = c_id[0];
      assign rt = c_tkt[0];
    end else begin : g_inner
      assign rv = c_valid[i+1];
      assign ri = c_id[i+1];
      assign rt = c_tkt[i+1];
    end
    lsch_cell #(.ID_W(ID_W), .TKT_W(TKT_W)) u_cell (
      .clk(clk), .rst_n(rst_n), .ctl(ctl), .key_id(kid_r), .key_tkt(ktkt_r),
      .flag_in(fin), .flag_out(c_flag[i]),
      .l_valid(lv), .l_id(li), .l_tkt(lt),
      .r_valid(rv), .r_id(ri), .r_tkt(rt),
      .valid_o(c_valid[i]), .id_o(c_id[i]), .tkt_o(c_tkt[i])
    );
  end

  lsch_div u_div (
    .clk(clk), .rst_n(rst_n), .start(dgo_r), .dividend(da_r), .divisor(db_r),
    .done(ddone), .quot(dq), .rem(drem)
  );

  // ticket sum clamped to the random span
  always_comb begin
    if ({{(W + 1 - SUM_W){1'b0}}, sum_r} > {1'b0, lsch_pkg::RAND_SPAN}) begin
      sumc = lsch_pkg::RAND_SPAN;
    end else begin
      sumc = W'(sum_r);
    end
  end

  assign acc_new   = sum_r + SUM_W'(c_tkt[0]);
  assign last_step = (step_r == CNT_W'(TABLE_DEPTH - 1));

  // controller
  always_comb begin
    state_nxt  = state_r;
    ctl.op     = lsch_pkg::OP_HOLD;
    step_nxt   = step_r;
    sum_nxt    = sum_r;
    cnt_nxt    = cnt_r;
    first_nxt  = first_r;
    choice_nxt = choice_r;
    found_nxt  = found_r;
    win_nxt    = win_r;
    ov_nxt     = 1'b0;
    ost_nxt    = ost_r;
    owin_nxt   = owin_r;
    dgo_nxt    = 1'b0;
    da_nxt     = da_r;
    db_nxt     = db_r;
    unique case (state_r)
      lsch_pkg::S_IDLE: begin
        if (start) begin
          if (in_req_type == lsch_pkg::REQ_INSERT) begin
            if ({1'b0, in_client_id} >= 8'(TABLE_DEPTH)) begin
              ov_nxt   = 1'b1;
              ost_nxt  = lsch_pkg::ST_BAD_ID;
              owin_nxt = '0;
            end else begin
              state_nxt = lsch_pkg::S_REMOVE;
            end
          end else begin
            state_nxt = lsch_pkg::S_SUM;
            step_nxt  = '0;
            sum_nxt   = '0;
            cnt_nxt   = '0;
          end
        end
      end
      lsch_pkg::S_REMOVE: begin
        ctl.op    = lsch_pkg::OP_REMOVE;
        state_nxt = lsch_pkg::S_INSERT;
      end
      lsch_pkg::S_INSERT: begin
        ctl.op    = lsch_pkg::OP_INSERT;
        state_nxt = lsch_pkg::S_IDLE;
        ov_nxt    = 1'b1;
        ost_nxt   = lsch_pkg::ST_INSERTED;
        owin_nxt  = '0;
      end
      lsch_pkg::S_SUM: begin
        // rotate the row once, gathering at slot zero
        ctl.op = lsch_pkg::OP_ROTATE;
        if (step_r == '0) begin
          first_nxt = c_id[0];
        end
        if (c_valid[0]) begin
          sum_nxt = acc_new;
          cnt_nxt = cnt_r + 1'b1;
        end
        step_nxt = step_r + 1'b1;
        if (last_step) begin
          state_nxt = lsch_pkg::S_EVAL;
        end
      end
      lsch_pkg::S_EVAL: begin
        if (cnt_r == '0 || sum_r == '0) begin
          state_nxt = lsch_pkg::S_IDLE;
          ov_nxt    = 1'b1;
          ost_nxt   = lsch_pkg::ST_IDLE;
          owin_nxt  = '0;
        end else if (cnt_r == CNT_W'(1)) begin
          state_nxt = lsch_pkg::S_IDLE;
          ov_nxt    = 1'b1;
          ost_nxt   = lsch_pkg::ST_WINNER;
          owin_nxt  = 6'(first_r);
        end else begin
          state_nxt = lsch_pkg::S_DIV1;
          dgo_nxt   = 1'b1;
          da_nxt    = lsch_pkg::RAND_SPAN;
          db_nxt    = sumc;
        end
      end
      lsch_pkg::S_DIV1: begin
        if (ddone) begin
          if ({1'b0, word_r} >= (lsch_pkg::RAND_SPAN - drem)) begin
            state_nxt = lsch_pkg::S_IDLE;
            ov_nxt    = 1'b1;
            ost_nxt   = lsch_pkg::ST_RETRY;
            owin_nxt  = '0;
          end else begin
            state_nxt = lsch_pkg::S_DIV2;
            dgo_nxt   = 1'b1;
            da_nxt    = {1'b0, word_r};
            db_nxt    = dq;
          end
        end
      end
      lsch_pkg::S_DIV2: begin
        if (ddone) begin
          choice_nxt = dq;
          state_nxt  = lsch_pkg::S_WALK;
          step_nxt   = '0;
          sum_nxt    = '0;
          found_nxt  = 1'b0;
        end
      end
      lsch_pkg::S_WALK: begin
        // cumulative walk, winner is first slot past the choice or the last one
        ctl.op = lsch_pkg::OP_ROTATE;
        if (c_valid[0] && !found_r) begin
          sum_nxt = acc_new;
          win_nxt = c_id[0];
          if ({{(W + 1 - SUM_W){1'b0}}, acc_new} > {1'b0, choice_r}) begin
            found_nxt = 1'b1;
          end
        end
        step_nxt = step_r + 1'b1;
        if (last_step) begin
          state_nxt = lsch_pkg::S_IDLE;
          ov_nxt    = 1'b1;
          ost_nxt   = lsch_pkg::ST_WINNER;
          owin_nxt  = (c_valid[0] && !found_r) ? 6'(c_id[0]) : 6'(win_r);
        end
      end
      default: state_nxt = lsch_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lsch_pkg::S_IDLE;
      ov_r    <= 1'b0;
      dgo_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      dgo_r   <= dgo_nxt;
    end
    if (start && state_r == lsch_pkg::S_IDLE) begin
      kid_r  <= ID_W'(in_client_id);
      ktkt_r <= TKT_W'(in_tickets);
      word_r <= in_random_word;
    end
    step_r   <= step_nxt;
    sum_r    <= sum_nxt;
    cnt_r    <= cnt_nxt;
    first_r  <= first_nxt;
    choice_r <= choice_nxt;
    found_r  <= found_nxt;
    win_r    <= win_nxt;
    ost_r    <= ost_nxt;
    owin_r   <= owin_nxt;
    da_r     <= da_nxt;
    db_r     <= db_nxt;
  end

  assign busy          = (state_r != lsch_pkg::S_IDLE);
  assign out_valid     = ov_r;
  assign out_status    = ost_r;
  assign out_winner_id = owin_r;

endmodule

// ===== design/lsch_cell.sv =====
// ----------------------------------------------------------------------------
// lsch_cell
// one slot of the sorted client row: holds one client and its tickets
// ----------------------------------------------------------------------------
module lsch_cell #(
  parameter int ID_W  = 6,
  parameter int TKT_W = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  lsch_pkg::cell_ctl_t ctl,
  input  logic [ID_W-1:0]    key_id,
  input  logic [TKT_W-1:0]   key_tkt,
  input  logic               flag_in,
  output logic               flag_out,
  input  logic               l_valid,
  input  logic [ID_W-1:0]    l_id,
  input  logic [TKT_W-1:0]   l_tkt,
  input  logic               r_valid,
  input  logic [ID_W-1:0]    r_id,
  input  logic [TKT_W-1:0]   r_tkt,
  output logic               valid_o,
  output logic [ID_W-1:0]    id_o,
  output logic [TKT_W-1:0]   tkt_o
);

  logic             valid_r, valid_nxt;
  logic [ID_W-1:0]  id_r, id_nxt;
  logic [TKT_W-1:0] tkt_r, tkt_nxt;
  logic             hit, pred;

  // new key belongs in front of this slot
  assign pred = !valid_r || (tkt_r < key_tkt) || ((tkt_r == key_tkt) && (id_r > key_id));
  assign hit  = valid_r && (id_r == key_id);
  assign flag_out = (ctl.op == lsch_pkg::OP_REMOVE) ? (flag_in | hit) : pred;

  // slot update
  always_comb begin
    valid_nxt = valid_r;
    id_nxt    = id_r;
    tkt_nxt   = tkt_r;
    case (ctl.op)
      lsch_pkg::OP_REMOVE: begin
        if (flag_in || hit) begin
          valid_nxt = r_valid;
          id_nxt    = r_id;
          tkt_nxt   = r_tkt;
        end
      end
      lsch_pkg::OP_INSERT: begin
        if (flag_in) begin
          valid_nxt = l_valid;
          id_nxt    = l_id;
          tkt_nxt   = l_tkt;
        end else if (pred) begin
          valid_nxt = 1'b1;
          id_nxt    = key_id;
          tkt_nxt   = key_tkt;
        end
      end
      lsch_pkg::OP_ROTATE: begin
        valid_nxt = r_valid;
        id_nxt    = r_id;
        tkt_nxt   = r_tkt;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    id_r  <= id_nxt;
    tkt_r <= tkt_nxt;
  end

  assign valid_o = valid_r;
  assign id_o    = id_r;
  assign tkt_o   = tkt_r;

endmodule

// ===== design/lsch_div.sv =====
// ----------------------------------------------------------------------------
// lsch_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module lsch_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [lsch_pkg::DIV_W-1:0] dividend,
  input  logic [lsch_pkg::DIV_W-1:0] divisor,
  output logic                       done,
  output logic [lsch_pkg::DIV_W-1:0] quot,
  output logic [lsch_pkg::DIV_W-1:0] rem
);

  localparam int W   = lsch_pkg::DIV_W;
  localparam int CW  = $clog2(W) + 1;

  logic [W-1:0]  quot_r, quot_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  dsr_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          run_r, run_nxt, done_r, done_nxt;
  logic [W:0]    trial, shifted;

  // one trial subtract a cycle
  always_comb begin
    shifted  = {rem_r, quot_r[W-1]};
    trial    = shifted - {1'b0, dsr_r};
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      quot_nxt = dividend;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      run_nxt  = 1'b1;
    end else if (run_r) begin
      if (!trial[W]) begin
        rem_nxt  = trial[W-1:0];
        quot_nxt = {quot_r[W-2:0], 1'b1};
      end else begin
        rem_nxt  = shifted[W-1:0];
        quot_nxt = {quot_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    cnt_r  <= cnt_nxt;
    if (start) begin
      dsr_r <= divisor;
    end
  end

  assign done = done_r;
  assign quot = quot_r;
  assign rem  = rem_r;

endmodule
